/* rtl/multi_level_priority_fifo_defines.svh */
// Assertion macros for the multi-level priority FIFO.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef MULTI_LEVEL_PRIORITY_FIFO_DEFINES_SVH
`define MULTI_LEVEL_PRIORITY_FIFO_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MLPF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mlpf: implication check failed");

// Next-cycle implication, disabled during reset.
`define MLPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mlpf: next-cycle check failed");

`endif

/* rtl/mlpf_pkg.sv */
// Shared constants, codes and types of the multi-level priority FIFO.
// No dependencies.
package mlpf_pkg;

  localparam int NUM_LEVELS  = 8;
  localparam int LEVEL_DEPTH = 16;
  localparam int STORE_DEPTH = NUM_LEVELS * LEVEL_DEPTH;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 4;
  localparam int LVL_IN_W = 4;
  localparam int STAT_W = 3;
  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int SLOT_W = $clog2(LEVEL_DEPTH);
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  // level counts and level numbers compare in this width
  localparam int CMP_W  = 5;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(5);

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef enum logic [0:0] {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_RANGE     = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_ALL_EMPTY = 3'd4
  } status_e;

  // One classified request on its way to the store.
  typedef struct packed {
    logic              wr_en;
    logic              rd_ok;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
    status_e           status;
    logic              all_empty;
  } cmd_t;

endpackage

/* rtl/mlpf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mlpf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mlpf_front.sv */
// Front end: holds active_levels and the per-level head/count pointers,
// checks each request and emits a classified command. Depends on mlpf_pkg.
module mlpf_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mlpf_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                            accept_i,
  input  logic                            kind_i,
  input  logic [mlpf_pkg::LVL_IN_W-1:0]   level_i,
  input  logic signed [mlpf_pkg::DATA_W-1:0] write_value_i,
  output mlpf_pkg::cmd_t                  cmd_o
);

  import mlpf_pkg::*;

  logic [CFG_W-1:0]  active_q;
  logic [SLOT_W-1:0] head_q [NUM_LEVELS];
  logic [SLOT_W-1:0] head_d [NUM_LEVELS];
  logic [CNT_W-1:0]  count_q [NUM_LEVELS];
  logic [CNT_W-1:0]  count_d [NUM_LEVELS];

  logic [CMP_W-1:0]  nlev;
  logic [LVL_W-1:0]  lvl_idx;
  logic              in_range;
  logic              empty_now;
  logic              empty_after;
  logic [SLOT_W-1:0] cur_head;
  logic [CNT_W-1:0]  cur_count;
  logic [SUM_W-1:0]  tail_sum;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W:0]   head_inc;
  logic [SLOT_W-1:0] head_next;

  always_comb begin
    nlev = (CMP_W'(active_q) > CMP_W'(NUM_LEVELS)) ? CMP_W'(NUM_LEVELS)
                                                   : CMP_W'(active_q);
    lvl_idx   = level_i[LVL_W-1:0];
    in_range  = CMP_W'(level_i) < nlev;
    cur_head  = head_q[lvl_idx];
    cur_count = count_q[lvl_idx];

    tail_sum = SUM_W'(cur_head) + SUM_W'(cur_count);
    if (tail_sum >= SUM_W'(LEVEL_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(LEVEL_DEPTH);
    end
    head_inc  = (SLOT_W + 1)'(cur_head) + (SLOT_W + 1)'(1);
    head_next = (head_inc >= (SLOT_W + 1)'(LEVEL_DEPTH)) ? '0 : head_inc[SLOT_W-1:0];

    empty_now = 1'b1;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (CMP_W'(i) < nlev && count_q[i] != '0) begin
        empty_now = 1'b0;
      end
    end
  end

  // Classify the request and work out the pointer updates.
  always_comb begin
    slot          = cur_head;
    cmd_o.wr_en   = 1'b0;
    cmd_o.rd_ok   = 1'b0;
    cmd_o.status  = ST_OK;
    cmd_o.wdata   = write_value_i;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      head_d[i]  = head_q[i];
      count_d[i] = count_q[i];
    end

    if (kind_i == KIND_INSERT) begin
      slot = tail_sum[SLOT_W-1:0];
      if (!in_range) begin
        cmd_o.status = ST_RANGE;
      end else if (cur_count >= CNT_W'(LEVEL_DEPTH)) begin
        cmd_o.status = ST_FULL;
      end else begin
        cmd_o.wr_en = 1'b1;
        count_d[lvl_idx] = cur_count + CNT_W'(1);
      end
    end else begin
      if (empty_now) begin
        cmd_o.status = ST_ALL_EMPTY;
      end else if (!in_range) begin
        cmd_o.status = ST_RANGE;
      end else if (cur_count == '0) begin
        cmd_o.status = ST_EMPTY;
      end else begin
        cmd_o.rd_ok = 1'b1;
        head_d[lvl_idx]  = head_next;
        count_d[lvl_idx] = cur_count - CNT_W'(1);
      end
    end

    cmd_o.addr = ADDR_W'(lvl_idx) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(slot);

    empty_after = 1'b1;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (CMP_W'(i) < nlev && count_d[i] != '0) begin
        empty_after = 1'b0;
      end
    end
    cmd_o.all_empty = empty_after;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_RESET;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
          head_q[i]  <= head_d[i];
          count_q[i] <= count_d[i];
        end
      end
    end
  end

endmodule

/* rtl/mlpf_cmd_fifo.sv */
// Short command queue between the front end and the store back end.
// Depends on mlpf_pkg.
module mlpf_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mlpf_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output mlpf_pkg::cmd_t cmd_o,
  output logic           full_o,
  output logic           empty_o
);

  import mlpf_pkg::*;

  cmd_t              slot_q [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  always_comb begin
    do_push  = push_i && (cnt_q != QCNT_W'(Q_DEPTH));
    do_pop   = pop_i && (cnt_q != '0);
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign cmd_o   = slot_q[rd_ptr_q];
  assign full_o  = (cnt_q == QCNT_W'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);

endmodule

/* rtl/mlpf_back.sv */
// Back end: drains the command queue, accesses the entry store and
// strobes one result per command. Depends on mlpf_pkg and mlpf_ram.
module mlpf_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  input  mlpf_pkg::cmd_t                    cmd_i,
  output logic                              pop_o,
  output logic                              result_valid_o,
  output logic [mlpf_pkg::STAT_W-1:0]       status_o,
  output logic signed [mlpf_pkg::DATA_W-1:0] read_value_o,
  output logic                              all_empty_o
);

  import mlpf_pkg::*;

  logic              valid_q;
  status_e           status_q;
  logic              rd_ok_q;
  logic              all_empty_q;
  logic [DATA_W-1:0] rdata;

  // The result side never stalls, so take a command every cycle that one is queued.
  assign pop_o = cmd_valid_i;

  mlpf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (pop_o && cmd_i.wr_en),
    .waddr_i (cmd_i.addr),
    .wdata_i (cmd_i.wdata),
    .raddr_i (cmd_i.addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q    <= cmd_i.status;
      rd_ok_q     <= cmd_i.rd_ok;
      all_empty_q <= cmd_i.all_empty;
    end
  end

  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign read_value_o   = rd_ok_q ? rdata : '0;
  assign all_empty_o    = all_empty_q;

endmodule

/* rtl/multi_level_priority_fifo.sv */
// Multi-level priority FIFO: one bounded FIFO per level in a shared store.
// Each request passes the command queue and the back end result register.
// Throughput: one request per cycle; the back end drains the command queue
// every cycle, so busy_o stays low in normal operation.
// Reset clears all heads and counts and sets active_levels to 5; the entry
// store is not cleared (only occupied slots are ever read).
`include "multi_level_priority_fifo_defines.svh"

module multi_level_priority_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mlpf_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              kind_i,
  input  logic [mlpf_pkg::LVL_IN_W-1:0]     level_i,
  input  logic signed [mlpf_pkg::DATA_W-1:0] write_value_i,
  output logic                              result_valid_o,
  output logic [mlpf_pkg::STAT_W-1:0]       status_o,
  output logic signed [mlpf_pkg::DATA_W-1:0] read_value_o,
  output logic                              all_empty_o
);

  import mlpf_pkg::*;

  logic accept;
  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic q_full;
  logic q_empty;
  logic q_pop;

  assign accept = start_i && !busy_o;
  assign busy_o = q_full;

  mlpf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .kind_i        (kind_i),
    .level_i       (level_i),
    .write_value_i (write_value_i),
    .cmd_o         (front_cmd)
  );

  mlpf_cmd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .cmd_i   (front_cmd),
    .pop_i   (q_pop),
    .cmd_o   (queue_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  mlpf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (!q_empty),
    .cmd_i          (queue_cmd),
    .pop_o          (q_pop),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .read_value_o   (read_value_o),
    .all_empty_o    (all_empty_o)
  );

  `MLPF_ASSERT_NEXT(a_accept_gives_result, start_i && !busy_o, ##1 result_valid_o)
  `MLPF_ASSERT_IMP(a_result_had_request, result_valid_o, $past(start_i && !busy_o, 2))
  `MLPF_ASSERT_IMP(a_read_zero_on_fail, result_valid_o && status_o != ST_OK, read_value_o == '0)

endmodule
